@@ rtl/core/cau_pkg.sv @@
// ---------------------------------------------------------------------------
// cau_pkg
// shared types and defaults for the complex arithmetic unit
// ---------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic    valid;
        t_action action;
        logic    neg_re;
        logic    neg_im;
        logic    div_zero;
        logic    ovf_re;
        logic    ovf_im;
    } t_ctrl;

endpackage

@@ rtl/core/cau_front.sv @@
// ---------------------------------------------------------------------------
// cau_front
// products, sums, numerators and denominator; sign/magnitude split
// ---------------------------------------------------------------------------
module cau_front #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  cau_pkg::t_action              i_action,
    input  logic signed [DATA_WIDTH-1:0]  i_a_re,
    input  logic signed [DATA_WIDTH-1:0]  i_a_im,
    input  logic signed [DATA_WIDTH-1:0]  i_b_re,
    input  logic signed [DATA_WIDTH-1:0]  i_b_im,
    output cau_pkg::t_ctrl                o_ctrl,
    output logic [2*DATA_WIDTH-1:0]       o_den,
    output logic [2*DATA_WIDTH:0]         o_r_re,
    output logic [2*DATA_WIDTH:0]         o_r_im,
    output logic [DATA_WIDTH:0]           o_q_re,
    output logic [DATA_WIDTH:0]           o_q_im
);

    localparam int PW  = 2 * DATA_WIDTH;
    localparam int VW  = 2 * DATA_WIDTH + 1;
    localparam int QW  = DATA_WIDTH + 1;
    localparam int NW  = VW + FRAC_BITS;
    localparam int SW  = DATA_WIDTH + 1;

    // stage 1: products and plain sums
    logic                   r_v1;
    cau_pkg::t_action       r_act1;
    logic signed [PW-1:0]   r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_r, r_sq_i;
    logic signed [SW-1:0]   r_s_re, r_s_im;
    logic signed [SW-1:0]   n_s_re, n_s_im;

    always_comb begin
        unique case (i_action)
            cau_pkg::ACT_SUB: begin
                n_s_re = SW'(i_a_re) - SW'(i_b_re);
                n_s_im = SW'(i_a_im) - SW'(i_b_im);
            end
            default: begin
                n_s_re = SW'(i_a_re) + SW'(i_b_re);
                n_s_im = SW'(i_a_im) + SW'(i_b_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_act1 <= i_action;
            r_p_rr <= i_a_re * i_b_re;
            r_p_ii <= i_a_im * i_b_im;
            r_p_ri <= i_a_re * i_b_im;
            r_p_ir <= i_a_im * i_b_re;
            r_sq_r <= i_b_re * i_b_re;
            r_sq_i <= i_b_im * i_b_im;
            r_s_re <= n_s_re;
            r_s_im <= n_s_im;
        end
    end

    // stage 2: exact combined values
    logic                   r_v2;
    cau_pkg::t_action       r_act2;
    logic signed [VW-1:0]   r_v_re, r_v_im;
    logic [PW-1:0]          r_den2;
    logic signed [VW-1:0]   n_v_re, n_v_im;

    always_comb begin
        unique case (r_act1)
            cau_pkg::ACT_MUL: begin
                n_v_re = VW'(r_p_rr) - VW'(r_p_ii);
                n_v_im = VW'(r_p_ri) + VW'(r_p_ir);
            end
            cau_pkg::ACT_DIV: begin
                n_v_re = VW'(r_p_rr) + VW'(r_p_ii);
                n_v_im = VW'(r_p_ir) - VW'(r_p_ri);
            end
            default: begin
                n_v_re = VW'(r_s_re);
                n_v_im = VW'(r_s_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_act2 <= r_act1;
            r_v_re <= n_v_re;
            r_v_im <= n_v_im;
            r_den2 <= $unsigned(r_sq_r) + $unsigned(r_sq_i);
        end
    end

    // stage 3: magnitudes, scaling, divider setup
    logic              neg_re, neg_im;
    logic [VW-1:0]     mag_re, mag_im;
    logic [NW-1:0]     num_re, num_im;
    cau_pkg::t_ctrl    n_ctrl;
    logic [VW-1:0]     n_r_re, n_r_im;

    always_comb begin
        neg_re = r_v_re[VW-1];
        neg_im = r_v_im[VW-1];
        mag_re = neg_re ? (~r_v_re + VW'(1)) : r_v_re;
        mag_im = neg_im ? (~r_v_im + VW'(1)) : r_v_im;
        num_re = NW'(mag_re) << FRAC_BITS;
        num_im = NW'(mag_im) << FRAC_BITS;
        n_ctrl.valid    = r_v2;
        n_ctrl.action   = r_act2;
        n_ctrl.neg_re   = neg_re;
        n_ctrl.neg_im   = neg_im;
        n_ctrl.div_zero = (r_den2 == '0);
        n_ctrl.ovf_re   = (PW'(num_re[NW-1:QW]) >= r_den2);
        n_ctrl.ovf_im   = (PW'(num_im[NW-1:QW]) >= r_den2);
        unique case (r_act2)
            cau_pkg::ACT_MUL: begin
                n_r_re = mag_re >> FRAC_BITS;
                n_r_im = mag_im >> FRAC_BITS;
            end
            cau_pkg::ACT_DIV: begin
                n_r_re = VW'(num_re[NW-1:QW]);
                n_r_im = VW'(num_im[NW-1:QW]);
            end
            default: begin
                n_r_re = mag_re;
                n_r_im = mag_im;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctrl.valid <= n_ctrl.valid;
        end
        if (i_en) begin
            o_ctrl.action   <= n_ctrl.action;
            o_ctrl.neg_re   <= n_ctrl.neg_re;
            o_ctrl.neg_im   <= n_ctrl.neg_im;
            o_ctrl.div_zero <= n_ctrl.div_zero;
            o_ctrl.ovf_re   <= n_ctrl.ovf_re;
            o_ctrl.ovf_im   <= n_ctrl.ovf_im;
            o_den           <= r_den2;
            o_r_re          <= n_r_re;
            o_r_im          <= n_r_im;
            o_q_re          <= num_re[QW-1:0];
            o_q_im          <= num_im[QW-1:0];
        end
    end

endmodule

@@ rtl/core/cau_div_step.sv @@
// ---------------------------------------------------------------------------
// cau_div_step
// one restoring division step for both parts; other actions pass through
// ---------------------------------------------------------------------------
module cau_div_step #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  cau_pkg::t_ctrl            i_ctrl,
    input  logic [2*DATA_WIDTH-1:0]   i_den,
    input  logic [2*DATA_WIDTH:0]     i_r_re,
    input  logic [2*DATA_WIDTH:0]     i_r_im,
    input  logic [DATA_WIDTH:0]       i_q_re,
    input  logic [DATA_WIDTH:0]       i_q_im,
    output cau_pkg::t_ctrl            o_ctrl,
    output logic [2*DATA_WIDTH-1:0]   o_den,
    output logic [2*DATA_WIDTH:0]     o_r_re,
    output logic [2*DATA_WIDTH:0]     o_r_im,
    output logic [DATA_WIDTH:0]       o_q_re,
    output logic [DATA_WIDTH:0]       o_q_im
);

    localparam int RW = 2 * DATA_WIDTH + 1;
    localparam int QW = DATA_WIDTH + 1;

    logic [RW-1:0] t_re, t_im, d_ext;
    logic          ge_re, ge_im;
    logic [RW-1:0] n_r_re, n_r_im;
    logic [QW-1:0] n_q_re, n_q_im;

    always_comb begin
        d_ext = RW'(i_den);
        t_re  = {i_r_re[RW-2:0], i_q_re[QW-1]};
        t_im  = {i_r_im[RW-2:0], i_q_im[QW-1]};
        ge_re = (t_re >= d_ext);
        ge_im = (t_im >= d_ext);
        if (i_ctrl.action == cau_pkg::ACT_DIV) begin
            n_r_re = ge_re ? (t_re - d_ext) : t_re;
            n_r_im = ge_im ? (t_im - d_ext) : t_im;
            n_q_re = {i_q_re[QW-2:0], ge_re};
            n_q_im = {i_q_im[QW-2:0], ge_im};
        end else begin
            n_r_re = i_r_re;
            n_r_im = i_r_im;
            n_q_re = i_q_re;
            n_q_im = i_q_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            o_ctrl.valid <= i_ctrl.valid;
        end
        if (i_en) begin
            o_ctrl.action   <= i_ctrl.action;
            o_ctrl.neg_re   <= i_ctrl.neg_re;
            o_ctrl.neg_im   <= i_ctrl.neg_im;
            o_ctrl.div_zero <= i_ctrl.div_zero;
            o_ctrl.ovf_re   <= i_ctrl.ovf_re;
            o_ctrl.ovf_im   <= i_ctrl.ovf_im;
            o_den           <= i_den;
            o_r_re          <= n_r_re;
            o_r_im          <= n_r_im;
            o_q_re          <= n_q_re;
            o_q_im          <= n_q_im;
        end
    end

endmodule

@@ rtl/core/cau_sat.sv @@
// ---------------------------------------------------------------------------
// cau_sat
// result selection, saturation, status and output register
// ---------------------------------------------------------------------------
module cau_sat #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  cau_pkg::t_ctrl                i_ctrl,
    input  logic [2*DATA_WIDTH:0]         i_r_re,
    input  logic [2*DATA_WIDTH:0]         i_r_im,
    input  logic [DATA_WIDTH:0]           i_q_re,
    input  logic [DATA_WIDTH:0]           i_q_im,
    output logic                          o_valid,
    output logic signed [DATA_WIDTH-1:0]  o_res_re,
    output logic signed [DATA_WIDTH-1:0]  o_res_im,
    output cau_pkg::t_status              o_status
);

    localparam int             MW   = 2 * DATA_WIDTH + 1;
    localparam logic [MW-1:0]  HALF = MW'(1) << (DATA_WIDTH - 1);

    logic [MW-1:0]          mag_re, mag_im;
    logic                   sat_re, sat_im;
    logic [DATA_WIDTH-1:0]  v_re, v_im;
    logic [DATA_WIDTH-1:0]  n_res_re, n_res_im;
    cau_pkg::t_status       n_status;

    function automatic logic [DATA_WIDTH:0] clamp(input logic neg, input logic [MW-1:0] mag,
                                                   input logic force_sat);
        logic [DATA_WIDTH-1:0] v;
        logic                  s;
        begin
            s = 1'b0;
            // an overflowed quotient keeps its sign whatever bits it holds
            if (neg && (mag != '0 || force_sat)) begin
                if (force_sat || mag > HALF) begin
                    s = 1'b1;
                    v = HALF[DATA_WIDTH-1:0];
                end else begin
                    v = ~mag[DATA_WIDTH-1:0] + DATA_WIDTH'(1);
                end
            end else begin
                if (force_sat || mag > HALF - MW'(1)) begin
                    s = 1'b1;
                    v = HALF[DATA_WIDTH-1:0] - DATA_WIDTH'(1);
                end else begin
                    v = mag[DATA_WIDTH-1:0];
                end
            end
            clamp = {s, v};
        end
    endfunction

    always_comb begin
        if (i_ctrl.action == cau_pkg::ACT_DIV) begin
            mag_re = MW'(i_q_re);
            mag_im = MW'(i_q_im);
            {sat_re, v_re} = clamp(i_ctrl.neg_re, mag_re, i_ctrl.ovf_re);
            {sat_im, v_im} = clamp(i_ctrl.neg_im, mag_im, i_ctrl.ovf_im);
        end else begin
            mag_re = i_r_re;
            mag_im = i_r_im;
            {sat_re, v_re} = clamp(i_ctrl.neg_re, mag_re, 1'b0);
            {sat_im, v_im} = clamp(i_ctrl.neg_im, mag_im, 1'b0);
        end
        if (i_ctrl.action == cau_pkg::ACT_DIV && i_ctrl.div_zero) begin
            n_res_re = '0;
            n_res_im = '0;
            n_status = cau_pkg::ST_DIV0;
        end else begin
            n_res_re = v_re;
            n_res_im = v_im;
            n_status = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_ctrl.valid;
        end
        if (i_en) begin
            o_res_re <= n_res_re;
            o_res_im <= n_res_im;
            o_status <= n_status;
        end
    end

endmodule

@@ rtl/core/complex_arithmetic_unit.sv @@
// ---------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined add, subtract, multiply and divide of two complex fixed-point values
// ---------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) carries the action and the two
//   operands a and b, signed fixed point with FRAC_BITS fraction bits
//   output channel (o_out_valid / i_out_ready) carries the result parts and
//   a status: ok, saturated, or division by zero (result forced to zero)
//   a transfer happens on a rising edge with valid and ready both high
//   the pipeline has three front stages for products and magnitudes, one
//   restoring divider stage per quotient bit (DATA_WIDTH + 1), and the
//   saturation/output register
//   throughput is one item per cycle; every action takes the same path
//   the whole pipeline advances together; while the output holds a result
//   that is not taken, every stage freezes and o_in_ready drops, so no item
//   is lost or repeated
//   reset (synchronous, active low) clears all valid bits; the datapath
//   registers keep whatever they hold
// ---------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_action,
    input  logic signed [DATA_WIDTH-1:0]  i_a_re,
    input  logic signed [DATA_WIDTH-1:0]  i_a_im,
    input  logic signed [DATA_WIDTH-1:0]  i_b_re,
    input  logic signed [DATA_WIDTH-1:0]  i_b_im,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [DATA_WIDTH-1:0]  o_res_re,
    output logic signed [DATA_WIDTH-1:0]  o_res_im,
    output logic [1:0]                    o_status
);

    localparam int RW = 2 * DATA_WIDTH + 1;   // remainder / magnitude width
    localparam int QW = DATA_WIDTH + 1;       // quotient bits, one per stage

    // global advance: output empty or being taken
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // per-stage buses of the divider chain
    cau_pkg::t_ctrl           ctrl  [0:QW];
    logic [2*DATA_WIDTH-1:0]  den   [0:QW];
    logic [RW-1:0]            r_re  [0:QW];
    logic [RW-1:0]            r_im  [0:QW];
    logic [QW-1:0]            q_re  [0:QW];
    logic [QW-1:0]            q_im  [0:QW];
    cau_pkg::t_status         status;

    // products, numerators, denominator, magnitudes
    cau_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in_valid),
        .i_action (cau_pkg::t_action'(i_action)),
        .i_a_re   (i_a_re),
        .i_a_im   (i_a_im),
        .i_b_re   (i_b_re),
        .i_b_im   (i_b_im),
        .o_ctrl   (ctrl[0]),
        .o_den    (den[0]),
        .o_r_re   (r_re[0]),
        .o_r_im   (r_im[0]),
        .o_q_re   (q_re[0]),
        .o_q_im   (q_im[0])
    );

    // restoring divider, one quotient bit per stage
    for (genvar g = 0; g < QW; g++) begin : g_div
        cau_div_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctrl  (ctrl[g]),
            .i_den   (den[g]),
            .i_r_re  (r_re[g]),
            .i_r_im  (r_im[g]),
            .i_q_re  (q_re[g]),
            .i_q_im  (q_im[g]),
            .o_ctrl  (ctrl[g+1]),
            .o_den   (den[g+1]),
            .o_r_re  (r_re[g+1]),
            .o_r_im  (r_im[g+1]),
            .o_q_re  (q_re[g+1]),
            .o_q_im  (q_im[g+1])
        );
    end

    // saturation and output register
    cau_sat #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_sat (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctrl   (ctrl[QW]),
        .i_r_re   (r_re[QW]),
        .i_r_im   (r_im[QW]),
        .i_q_re   (q_re[QW]),
        .i_q_im   (q_im[QW]),
        .o_valid  (o_out_valid),
        .o_res_re (o_res_re),
        .o_res_im (o_res_im),
        .o_status (status)
    );

    assign o_status = status;

endmodule

@@ test/complex_arithmetic_unit_test.sv @@
// ---------------------------------------------------------------------------
// complex_arithmetic_unit_test
// self-checking bench for the complex fixed-point add/sub/mul/div unit
// ---------------------------------------------------------------------------
// a table of directed operand sets runs first, then about 2000 random ones
// biased toward small values, extremes and zero divisors; every result is
// compared field by field with an in-order queue filled by a fixed-point
// predictor; both channels idle and stall at random
// ---------------------------------------------------------------------------
module complex_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW        = cau_pkg::DATA_WIDTH;
    localparam int FB        = cau_pkg::FRAC_BITS;
    localparam int N_RANDOM  = 2000;
    localparam int MAX_CYCLE = 400000;
    localparam int DRAIN     = DW + 20;

    typedef logic signed [DW-1:0] t_q;

    typedef struct {
        t_q               re;
        t_q               im;
        cau_pkg::t_status st;
    } t_cplx_res;

    // directed operand sets; has_exp marks rows whose answer is typed in
    typedef struct {
        cau_pkg::t_action act;
        t_q               ar, ai, br, bi;
        logic             has_exp;
        t_cplx_res        res;
    } t_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_ready;
    logic [1:0] i_action;
    t_q      i_a_re, i_a_im, i_b_re, i_b_im;
    logic    o_out_valid;
    logic    i_out_ready;
    t_q      o_res_re, o_res_im;
    logic [1:0] o_status;

    complex_arithmetic_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_a_re     (i_a_re),
        .i_a_im     (i_a_im),
        .i_b_re     (i_b_re),
        .i_b_im     (i_b_im),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_res_re   (o_res_re),
        .o_res_im   (o_res_im),
        .o_status   (o_status)
    );

    t_cplx_res pending_results[$];
    int        n_errors;
    int        n_checked;
    int        n_sent;
    int        cycle_cnt = 0;
    int        n_div0, n_sat;

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[complex_arithmetic_unit] ERROR");
            $finish;
        end
    end

    // signed value to saturated field, flags the status
    function automatic t_q clamp_part(input logic signed [127:0] v, inout logic sat);
        logic signed [127:0] hi, lo;
        hi = (128'sd1 <<< (DW - 1)) - 1;
        lo = -(128'sd1 <<< (DW - 1));
        if (v > hi) begin
            sat = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // truncate toward zero: n / d on the magnitude
    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic signed [127:0] mag;
        mag = (n < 0) ? -n : n;
        mag = mag / d;
        return (n < 0) ? -mag : mag;
    endfunction

    // expected result of one operation
    function automatic t_cplx_res complex_result(input cau_pkg::t_action act, input t_q ar,
                                                 input t_q ai, input t_q br, input t_q bi);
        logic signed [127:0] xr, xi, yr, yi, vr, vi, den;
        logic                sat;
        t_cplx_res           r;
        xr = ar; xi = ai; yr = br; yi = bi;
        sat = 1'b0;
        case (act)
            cau_pkg::ACT_ADD: begin
                vr = xr + yr;
                vi = xi + yi;
            end
            cau_pkg::ACT_SUB: begin
                vr = xr - yr;
                vi = xi - yi;
            end
            cau_pkg::ACT_MUL: begin
                vr = div_trunc(xr * yr - xi * yi, 128'sd1 <<< FB);
                vi = div_trunc(xr * yi + xi * yr, 128'sd1 <<< FB);
            end
            default: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.st = cau_pkg::ST_DIV0;
                    return r;
                end
                vr = div_trunc((xr * yr + xi * yi) <<< FB, den);
                vi = div_trunc((xi * yr - xr * yi) <<< FB, den);
            end
        endcase
        r.re = clamp_part(vr, sat);
        r.im = clamp_part(vi, sat);
        r.st = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        return r;
    endfunction

    function automatic t_q pick_operand();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return t_q'(16'h8000);
            1:       return t_q'(16'h7fff);
            2:       return '0;
            3, 4:    return t_q'($signed($urandom_range(0, 1023)) - 512);
            default: return t_q'($urandom);
        endcase
    endfunction

    // one input transfer: idle, raise valid, wait for acceptance
    task automatic send_item(input cau_pkg::t_action act, input t_q ar, input t_q ai,
                             input t_q br, input t_q bi);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_a_re     <= ar;
        i_a_im     <= ai;
        i_b_re     <= br;
        i_b_im     <= bi;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // transfer taken on this edge
        pending_results.push_back(complex_result(act, ar, ai, br, bi));
        n_sent++;
    endtask

    // output side: random stalls, one draw per result
    initial begin : result_side
        int  stall;
        t_cplx_res exp_res;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            // a result transfer happened at this edge
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result re=%0d im=%0d st=%0d",
                             o_res_re, o_res_im, o_status);
            end else begin
                exp_res = pending_results.pop_front();
                n_checked++;
                if (exp_res.st == cau_pkg::ST_DIV0) n_div0++;
                if (exp_res.st == cau_pkg::ST_SAT)  n_sat++;
                if (o_res_re !== exp_res.re || o_res_im !== exp_res.im
                    || o_status !== exp_res.st) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch #%0d: exp %0d %0d st=%0d, got %0d %0d st=%0d",
                                 n_checked, exp_res.re, exp_res.im, exp_res.st,
                                 o_res_re, o_res_im, o_status);
                end
            end
        end
    end

    t_row dir_rows[] = '{
        // add of the extremes saturates both ways
        '{cau_pkg::ACT_ADD, 16'sh7fff, -16'sh8000, 16'sh0001, -16'sh0001, 1'b1,
          '{16'sh7fff, -16'sh8000, cau_pkg::ST_SAT}},
        '{cau_pkg::ACT_ADD, 16'sh0100, 16'sh0200, 16'sh0100, -16'sh0300, 1'b1,
          '{16'sh0200, -16'sh0100, cau_pkg::ST_OK}},
        '{cau_pkg::ACT_SUB, -16'sh8000, 16'sh7fff, 16'sh0001, -16'sh0001, 1'b1,
          '{-16'sh8000, 16'sh7fff, cau_pkg::ST_SAT}},
        '{cau_pkg::ACT_SUB, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1,
          '{16'sh0000, 16'sh0000, cau_pkg::ST_OK}},
        // (1+i)*(1-i) = 2
        '{cau_pkg::ACT_MUL, 16'sh0100, 16'sh0100, 16'sh0100, -16'sh0100, 1'b1,
          '{16'sh0200, 16'sh0000, cau_pkg::ST_OK}},
        '{cau_pkg::ACT_MUL, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1'b1,
          '{16'sh0000, 16'sh7fff, cau_pkg::ST_SAT}},
        // tiny negative product truncates toward zero
        '{cau_pkg::ACT_MUL, -16'sh0001, 16'sh0000, 16'sh0001, 16'sh0000, 1'b1,
          '{16'sh0000, 16'sh0000, cau_pkg::ST_OK}},
        '{cau_pkg::ACT_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, 1'b0,
          '{0, 0, cau_pkg::ST_OK}},
        // division by zero denominator
        '{cau_pkg::ACT_DIV, 16'sh7fff, -16'sh8000, 16'sh0000, 16'sh0000, 1'b1,
          '{16'sh0000, 16'sh0000, cau_pkg::ST_DIV0}},
        '{cau_pkg::ACT_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1,
          '{16'sh0000, 16'sh0000, cau_pkg::ST_DIV0}},
        '{cau_pkg::ACT_DIV, 16'sh0200, 16'sh0000, 16'sh0100, 16'sh0000, 1'b1,
          '{16'sh0200, 16'sh0000, cau_pkg::ST_OK}},
        // huge quotient from smallest divisor
        '{cau_pkg::ACT_DIV, 16'sh7fff, -16'sh8000, 16'sh0001, 16'sh0000, 1'b1,
          '{16'sh7fff, -16'sh8000, cau_pkg::ST_SAT}},
        '{cau_pkg::ACT_DIV, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1'b0,
          '{0, 0, cau_pkg::ST_OK}},
        '{cau_pkg::ACT_DIV, 16'sh0100, 16'sh0000, 16'sh0300, 16'sh0000, 1'b0,
          '{0, 0, cau_pkg::ST_OK}},
        '{cau_pkg::ACT_DIV, -16'sh0100, 16'sh0055, 16'sh0000, -16'sh0300, 1'b0,
          '{0, 0, cau_pkg::ST_OK}},
        '{cau_pkg::ACT_DIV, 16'sh0001, 16'sh0000, 16'sh7fff, 16'sh7fff, 1'b0,
          '{0, 0, cau_pkg::ST_OK}}
    };

    initial begin : stimulus
        t_cplx_res exp_res;
        int        wait_cnt;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_action   = cau_pkg::ACT_ADD;
        i_a_re = '0; i_a_im = '0; i_b_re = '0; i_b_im = '0;
        n_errors = 0; n_checked = 0; n_sent = 0;
        n_div0 = 0; n_sat = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            exp_res = complex_result(dir_rows[k].act, dir_rows[k].ar, dir_rows[k].ai,
                                     dir_rows[k].br, dir_rows[k].bi);
            // the typed-in answers back up the predictor itself
            if (dir_rows[k].has_exp && (exp_res.re !== dir_rows[k].res.re
                                        || exp_res.im !== dir_rows[k].res.im
                                        || exp_res.st !== dir_rows[k].res.st)) begin
                n_errors++;
                $display("directed row %0d: table and predictor disagree", k);
            end
            send_item(dir_rows[k].act, dir_rows[k].ar, dir_rows[k].ai,
                      dir_rows[k].br, dir_rows[k].bi);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // hold off once until the pipeline has fully drained
            if (n == N_RANDOM / 2) begin
                i_in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            send_item(cau_pkg::t_action'($urandom_range(0, 3)), pick_operand(),
                      pick_operand(),
                      ($urandom_range(0, 15) == 0) ? t_q'(0) : pick_operand(),
                      ($urandom_range(0, 15) == 0) ? t_q'(0) : pick_operand());
        end
        i_in_valid <= 1'b0;

        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (DRAIN) @(posedge i_clk);

        $display("sent %0d operand sets, checked %0d results", n_sent, n_checked);
        $display("%0d saturated, %0d zero divisors, %0d failures", n_sat, n_div0, n_errors);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("[complex_arithmetic_unit] OK");
        end else begin
            $display("%0d results never arrived", pending_results.size());
            $display("[complex_arithmetic_unit] ERROR");
        end
        $finish;
    end

endmodule
